// ===== rtl/core/rscc_pkg.sv =====
// shared types, constants and helpers for the range set/clear counter
// no dependencies; used by rscc_bitmap and range_set_clear_counter_unit
package rscc_pkg;

	localparam int MAX_POSITIONS = 4096;
	localparam int WORD_BITS     = 64;
	localparam int POS_W         = 13;
	localparam int NUM_WORDS     = (MAX_POSITIONS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W        = $clog2(NUM_WORDS);
	localparam int BIT_W         = $clog2(WORD_BITS);
	localparam int CNT_W         = $clog2(WORD_BITS + 1);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [BIT_W-1:0]     bit_idx_t;
	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// one word operation issued by the sequencer
	typedef struct packed {
		logic     rd_en;
		addr_t    addr;
		logic     first_word;
		logic     last_word;
		bit_idx_t b0;
		bit_idx_t b1;
		logic     set_op;
	} word_op_t;

	// what comes back from the bitmap
	typedef struct packed {
		logic  busy;
		logic  diff_valid;
		word_t diff;
	} bitmap_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	function automatic cnt_t popcount(input word_t v);
		cnt_t c;
		c = '0;
		for (int i = 0; i < WORD_BITS; i++) c = c + cnt_t'(v[i]);
		return c;
	endfunction

endpackage

// ===== rtl/core/rscc_bitmap.sv =====
// mark bitmap memory with read-modify-write datapath
// depends on rscc_pkg
module rscc_bitmap (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fill,
	input  rscc_pkg::word_op_t      op,
	output rscc_pkg::bitmap_status_t st
);

	rscc_pkg::word_t  mem_q [rscc_pkg::NUM_WORDS];
	logic [rscc_pkg::NUM_WORDS-1:0] valid_q;

	rscc_pkg::word_op_t op_s1;
	logic               op_vld_s1;
	logic               rd_vld_s1;
	rscc_pkg::word_t    rd_data_s1;

	rscc_pkg::word_t    word_s1;
	rscc_pkg::word_t    lo_mask;
	rscc_pkg::word_t    hi_mask;
	rscc_pkg::word_t    mask;
	rscc_pkg::word_t    new_word;
	rscc_pkg::word_t    changed;
	rscc_pkg::bit_idx_t hi_shift;

	rscc_pkg::word_t    diff_s2;
	logic               diff_vld_s2;

	// never-written words read as all ones
	assign word_s1  = rd_vld_s1 ? rd_data_s1 : '1;
	assign hi_shift = rscc_pkg::bit_idx_t'(rscc_pkg::WORD_BITS - 1) - op_s1.b1;
	assign lo_mask  = op_s1.first_word ? ({rscc_pkg::WORD_BITS{1'b1}} << op_s1.b0) : '1;
	assign hi_mask  = op_s1.last_word ? ({rscc_pkg::WORD_BITS{1'b1}} >> hi_shift) : '1;
	assign mask     = lo_mask & hi_mask;
	assign new_word = op_s1.set_op ? (word_s1 | mask) : (word_s1 & ~mask);
	assign changed  = mask & (op_s1.set_op ? ~word_s1 : word_s1);

	always_ff @(posedge clk) begin
		if (op.rd_en) begin
			rd_data_s1 <= mem_q[op.addr];
		end
		if (op_vld_s1) begin
			mem_q[op_s1.addr] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op;
		diff_s2 <= changed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			op_vld_s1   <= 1'b0;
			rd_vld_s1   <= 1'b0;
			diff_vld_s2 <= 1'b0;
		end else begin
			op_vld_s1   <= op.rd_en;
			rd_vld_s1   <= valid_q[op.addr];
			diff_vld_s2 <= op_vld_s1;
			if (fill) begin
				valid_q <= '0;
			end else if (op_vld_s1) begin
				valid_q[op_s1.addr] <= 1'b1;
			end
		end
	end

	assign st.busy       = op_vld_s1 | diff_vld_s2;
	assign st.diff_valid = diff_vld_s2;
	assign st.diff       = diff_s2;

endmodule

// ===== rtl/core/range_set_clear_counter_unit.sv =====
// top level of the range set/clear counter: sequencer, count and handshakes
// depends on rscc_pkg and rscc_bitmap
//
// usage
//  - input channel (in_valid/in_ready) carries func, first_position and
//    last_position; one transfer is one range operation
//  - output channel (out_valid/out_ready) carries marked_count, one transfer
//    per input transfer, in order
//  - cfg_wr_en/cfg_wr_data write positions_in_use (saturated to 4096); this
//    marks every position and reloads the count; write only while idle
//  - an item runs from the input transfer through the word scan and a
//    drain to output valid; the word scan runs one memory read-modify-
//    write per cycle, so the bitmap memory (one read port, one write
//    port) sets the rate, and the drain waits until the memory and count
//    pipeline (read, changed-bits and popcount stages) is empty; an empty
//    range skips the scan and goes straight to the done state
//  - one item is in work at a time; the next input is taken as soon as
//    the previous result sits in the output register
//  - if the receiver stalls, the finished count waits in the output
//    register and the following item finishes but waits in the done state
//  - reset marks every position (per-word valid bits cleared), sets
//    positions_in_use and the count to 4096; no clearing pass is needed
module range_set_clear_counter_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [rscc_pkg::POS_W-1:0] cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [rscc_pkg::POS_W-1:0] first_position,
	input  logic [rscc_pkg::POS_W-1:0] last_position,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [rscc_pkg::POS_W-1:0] marked_count
);

	rscc_pkg::state_t state_q, state_d;

	rscc_pkg::pos_t   n_q;
	rscc_pkg::pos_t   total_q;
	rscc_pkg::pos_t   cfg_clamped;

	// per-item registers
	rscc_pkg::addr_t    w_cur_q;
	rscc_pkg::addr_t    w_lo_q;
	rscc_pkg::addr_t    w_hi_q;
	rscc_pkg::bit_idx_t b0_q;
	rscc_pkg::bit_idx_t b1_q;
	logic               set_q;

	// range decode of the incoming item
	rscc_pkg::pos_t first_eff;
	rscc_pkg::pos_t last_eff;
	rscc_pkg::pos_t lo_bit;
	rscc_pkg::pos_t hi_bit;
	logic           nonempty;

	logic accept;
	logic advance;
	logic load_out;

	rscc_pkg::word_op_t       op;
	rscc_pkg::bitmap_status_t bm_st;

	// popcount stage of the changed bits
	rscc_pkg::cnt_t cnt_s3;
	logic           cnt_vld_s3;

	logic                     out_vld_q;
	rscc_pkg::pos_t           out_cnt_q;

	assign cfg_clamped = (cfg_wr_data > rscc_pkg::pos_t'(rscc_pkg::MAX_POSITIONS))
		? rscc_pkg::pos_t'(rscc_pkg::MAX_POSITIONS) : cfg_wr_data;

	// position zero counts as position one, the end clamps to n
	assign first_eff = (first_position == '0) ? rscc_pkg::pos_t'(1) : first_position;
	assign last_eff  = (last_position > n_q) ? n_q : last_position;
	assign nonempty  = (first_eff <= last_eff);
	assign lo_bit    = first_eff - rscc_pkg::pos_t'(1);
	assign hi_bit    = last_eff - rscc_pkg::pos_t'(1);

	rscc_bitmap u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.fill   (cfg_wr_en),
		.op     (op),
		.st     (bm_st)
	);

	// sequencer
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		accept     = 1'b0;
		advance    = 1'b0;
		load_out   = 1'b0;
		op.rd_en      = 1'b0;
		op.addr       = w_cur_q;
		op.first_word = (w_cur_q == w_lo_q);
		op.last_word  = (w_cur_q == w_hi_q);
		op.b0         = b0_q;
		op.b1         = b1_q;
		op.set_op     = set_q;
		case (state_q)
			rscc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					accept  = 1'b1;
					state_d = nonempty ? rscc_pkg::ST_SCAN : rscc_pkg::ST_DONE;
				end
			end
			rscc_pkg::ST_SCAN: begin
				// one word read per cycle, addresses never repeat within an item
				op.rd_en = 1'b1;
				advance  = 1'b1;
				if (w_cur_q == w_hi_q) begin
					state_d = rscc_pkg::ST_DRAIN;
				end
			end
			rscc_pkg::ST_DRAIN: begin
				if (!bm_st.busy && !cnt_vld_s3) begin
					state_d = rscc_pkg::ST_DONE;
				end
			end
			rscc_pkg::ST_DONE: begin
				if (!out_vld_q || out_ready) begin
					load_out = 1'b1;
					state_d  = rscc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rscc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rscc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			w_cur_q <= lo_bit[rscc_pkg::BIT_W +: rscc_pkg::ADDR_W];
			w_lo_q  <= lo_bit[rscc_pkg::BIT_W +: rscc_pkg::ADDR_W];
			w_hi_q  <= hi_bit[rscc_pkg::BIT_W +: rscc_pkg::ADDR_W];
			b0_q    <= lo_bit[rscc_pkg::BIT_W-1:0];
			b1_q    <= hi_bit[rscc_pkg::BIT_W-1:0];
			set_q   <= func;
		end else if (advance) begin
			w_cur_q <= w_cur_q + rscc_pkg::addr_t'(1);
		end
		cnt_s3 <= rscc_pkg::popcount(bm_st.diff);
	end

	// count, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= rscc_pkg::pos_t'(rscc_pkg::MAX_POSITIONS);
			total_q    <= rscc_pkg::pos_t'(rscc_pkg::MAX_POSITIONS);
			cnt_vld_s3 <= 1'b0;
			out_vld_q  <= 1'b0;
			out_cnt_q  <= '0;
		end else begin
			cnt_vld_s3 <= bm_st.diff_valid;
			if (cfg_wr_en) begin
				n_q     <= cfg_clamped;
				total_q <= cfg_clamped;
			end else if (cnt_vld_s3) begin
				// set adds newly marked bits, clear removes formerly marked ones
				total_q <= set_q ? (total_q + rscc_pkg::pos_t'(cnt_s3))
				                 : (total_q - rscc_pkg::pos_t'(cnt_s3));
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
				out_cnt_q <= total_q;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_vld_q;
	assign marked_count = out_cnt_q;

	// the count can never pass the number of tracked positions
	assert property (@(posedge clk) disable iff (!arst_n) total_q <= n_q)
		else $error("marked total exceeds positions in use");

	// a configuration write reloads the count with the tracked size
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (total_q == n_q))
		else $error("count not reloaded after configuration write");

	// no bitmap work may be pending while a new item can be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rscc_pkg::ST_IDLE) |-> (!bm_st.busy && !cnt_vld_s3))
		else $error("bitmap pipeline busy while idle");

	// a single word never changes more bits than it holds
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_vld_s3 |-> (cnt_s3 <= rscc_pkg::cnt_t'(rscc_pkg::WORD_BITS)))
		else $error("changed-bit count out of range");

	// the output register is only loaded from the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (state_q == rscc_pkg::ST_DONE && !bm_st.busy))
		else $error("result loaded before the item finished");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for range_set_clear_counter_unit: directed and random range
// operations under several tracked-position settings, checked against a per-position model
// depends on rscc_pkg and the rtl of range_set_clear_counter_unit
module testbench;

	// operation codes carried on func
	localparam bit OP_CLEAR = 1'b0;
	localparam bit OP_SET   = 1'b1;

	localparam int POS_LIMIT    = (1 << rscc_pkg::POS_W) - 1;	// largest field value
	localparam int MAX_POS      = rscc_pkg::MAX_POSITIONS;
	localparam int HOLD_CYCLES  = 400;	// long receiver hold-off
	localparam int SETTLE_CYCLES = 8;	// quiet time before a register write
	localparam int DRAIN_CYCLES = 80;	// beyond the longest item latency
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int NO_CHECK     = -1;	// row count comes from the predictor

	typedef rscc_pkg::pos_t pos_t;

	typedef struct {
		bit op;
		int first;
		int last;
		int count;
	} range_row_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	pos_t cfg_wr_data;
	logic in_valid;
	logic in_ready;
	logic func;
	pos_t first_position;
	pos_t last_position;
	logic out_valid;
	logic out_ready;
	pos_t marked_count;

	// predictor state: one flag per position, the tracked length and the live count
	bit   pos_marked [0:MAX_POS-1];
	int   positions_live;
	int   marked_live;

	pos_t count_expect_q [$];	// expected counts, oldest first
	pos_t count_wanted;
	int   error_count;
	int   cycle_count;
	bit   idle_en;		// random gaps on both sides
	bit   hold_off_req;		// main asks the receiver for a long hold-off

	// directed ranges; counts typed in where they follow directly from the
	// previous rows, starting from reset with all 4096 positions marked
	range_row_t directed_rows [22] = '{
		'{OP_SET,   1,    4096, 4096},	// full range, already marked
		'{OP_CLEAR, 1,    4096, 0},	// full range cleared
		'{OP_CLEAR, 1,    1,    0},	// clear of an unmarked position
		'{OP_SET,   0,    3,    3},	// first position zero counts as one
		'{OP_SET,   4096, 4096, 4},	// last position alone
		'{OP_SET,   8191, 8191, 4},	// both past the end: reversed after clamping
		'{OP_SET,   10,   5,    4},	// reversed range
		'{OP_CLEAR, 0,    8191, 0},	// zero first and maximum last
		'{OP_SET,   64,   65,   2},	// across a word boundary
		'{OP_SET,   63,   64,   3},	// partly marked already
		'{OP_CLEAR, 64,   64,   2},	// last bit of a word
		'{OP_SET,   1,    64,   65},	// whole first word
		'{OP_CLEAR, 2,    4095, 1},	// nearly everything
		'{OP_SET,   4033, 4096, 65},	// whole last word
		'{OP_SET,   1,    8191, 4096},	// past the end, clamped
		'{OP_CLEAR, 4097, 8191, 4096},	// starts past the end
		'{OP_CLEAR, 0,    0,    4096},	// zero first and zero last
		'{OP_CLEAR, 128,  4000, NO_CHECK},
		'{OP_SET,   129,  129,  NO_CHECK},
		'{OP_CLEAR, 1,    4096, 0},
		'{OP_SET,   1000, 3000, 2001},
		'{OP_SET,   4095, 8191, 2003}
	};

	range_set_clear_counter_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.first_position(first_position),
		.last_position (last_position),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.marked_count  (marked_count)
	);

	always #5 clk = ~clk;

	// load the tracked length: saturate, mark everything, reload the count
	function automatic void load_positions(int value);
		int v;
		v = value & POS_LIMIT;
		if (v > MAX_POS) v = MAX_POS;
		positions_live = v;
		foreach (pos_marked[p]) pos_marked[p] = 1'b1;
		marked_live = v;
	endfunction

	// apply one range operation to the model and return the new count
	function automatic pos_t apply_range(bit op, int first, int last);
		int lo;
		int hi;
		lo = (first == 0) ? 1 : first;
		hi = (last > positions_live) ? positions_live : last;
		// a reversed range falls straight through the loop
		for (int p = lo; p <= hi; p++) begin
			if (op == OP_SET && !pos_marked[p-1]) begin
				pos_marked[p-1] = 1'b1;
				marked_live++;
			end else if (op == OP_CLEAR && pos_marked[p-1]) begin
				pos_marked[p-1] = 1'b0;
				marked_live--;
			end
		end
		return pos_t'(marked_live);
	endfunction

	// gap length: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 3);
		else if (r < 95) return $urandom_range(4, 10);
		else return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// append one expected count behind the ones already waiting
	task automatic queue_expected(pos_t value);
		count_expect_q.insert(count_expect_q.size(), value);
	endtask

	// offer one range; returns at the rising edge of its transfer, valid still high
	task automatic send_range(bit op, int first, int last, int typed_count);
		int gap;
		pos_t predicted;
		@(negedge clk);
		gap = (idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid       <= 1'b1;
		func           <= op;
		first_position <= pos_t'(first);
		last_position  <= pos_t'(last);
		do @(posedge clk); while (!in_ready);
		// transfer taken: the model moves on, the expectation is queued
		predicted = apply_range(op, first, last);
		if (typed_count == NO_CHECK) queue_expected(predicted);
		else queue_expected(pos_t'(typed_count));
	endtask

	task automatic wait_drained();
		while (count_expect_q.size() != 0) @(posedge clk);
	endtask

	// register write with the block idle: stop offering, let results drain, settle
	task automatic write_positions(int value);
		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= pos_t'(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		load_positions(value);
	endtask

	// mostly ranges inside the tracked span, the rest at the edges or plain noise
	task automatic random_range(output bit op, output int first, output int last);
		int span;
		int pick;
		int tmp;
		span = (positions_live == 0) ? 1 : positions_live;
		op   = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// short range, may run past the end
			first = $urandom_range(1, span);
			last  = first + $urandom_range(0, 80);
		end else if (pick < 70) begin
			first = $urandom_range(1, span);
			last  = $urandom_range(1, span);
			if (first > last) begin
				tmp   = first;
				first = last;
				last  = tmp;
			end
		end else if (pick < 78) begin
			// reversed
			first = $urandom_range(1, span);
			last  = $urandom_range(0, first - 1);
		end else if (pick < 86) begin
			// past the end
			first = $urandom_range(1, span);
			last  = $urandom_range(span, POS_LIMIT);
		end else if (pick < 93) begin
			// zero first position
			first = 0;
			last  = $urandom_range(0, span);
		end else begin
			// anything the fields can hold
			first = $urandom_range(0, POS_LIMIT);
			last  = $urandom_range(0, POS_LIMIT);
		end
	endtask

	task automatic run_random(int n);
		bit op;
		int first;
		int last;
		repeat (n) begin
			random_range(op, first, last);
			send_range(op, first, last, NO_CHECK);
		end
	endtask

	// receiver: random stalls, or one long hold-off when main asks for it
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				for (int held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 99) < 25) begin
				out_ready <= 1'b0;
				repeat (pick_gap()) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (count_expect_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, count=%0d",
					marked_count));
			end else begin
				count_wanted = count_expect_q.pop_front();
				if (marked_count !== count_wanted)
					report_mismatch($sformatf("marked_count=%0d expected %0d",
						marked_count, count_wanted));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** range_set_clear_counter_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_valid       = 1'b0;
		func           = OP_CLEAR;
		first_position = '0;
		last_position  = '0;
		error_count    = 0;
		cycle_count    = 0;
		idle_en        = 1'b1;
		hold_off_req   = 1'b0;
		load_positions(MAX_POS);	// reset state of the block

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part from reset, then random at the reset length
		foreach (directed_rows[i])
			send_range(directed_rows[i].op, directed_rows[i].first,
				directed_rows[i].last, directed_rows[i].count);
		run_random(300);

		// all-ones write saturates; no idling in this stretch
		idle_en = 1'b0;
		write_positions(POS_LIMIT);
		run_random(200);
		idle_en = 1'b1;

		// nothing tracked: every range is empty
		write_positions(0);
		run_random(30);

		write_positions(1);
		run_random(40);

		// just above the maximum, with the long receiver hold-off in the middle
		write_positions(MAX_POS + 1);
		run_random(60);
		hold_off_req = 1'b1;
		run_random(90);

		write_positions(MAX_POS);
		run_random(200);

		// one word and one word plus a bit
		write_positions(rscc_pkg::WORD_BITS);
		run_random(100);
		write_positions(rscc_pkg::WORD_BITS + 1);
		run_random(100);

		repeat (4) begin
			write_positions($urandom_range(1, MAX_POS));
			run_random(100);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("** range_set_clear_counter_unit: PASSED **");
		end else begin
			$display("** range_set_clear_counter_unit: FAILED **");
		end
		$finish;
	end

endmodule
